@@ design/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the section stream deframer.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int JOB_QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int HEADER_BYTES    = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_COOKIE = 2'd1;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_OK      = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_COOKIE    = 2'd2;
    localparam logic [1:0] ERR_TRAILING  = 2'd3;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_PAYLOAD,
        JOB_ERROR
    } job_op_t;

    // one classified byte, handed from the front to the back
    typedef struct packed {
        job_op_t     op;
        logic        finish;     // a success result follows
        logic [15:0] stype;
        logic [31:0] slen;
        logic [7:0]  data;
        logic        send;       // last payload byte of the section
        logic [1:0]  err;
    } ssd_job_t;

endpackage

@@ design/section_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// section_stream_deframer
// Section header and payload deframer for a saved-state byte stream.
// ----------------------------------------------------------------------------
// path: a result passes from the parser through the job queue into the output register
// throughput: one byte per cycle in while the queue is not full, one result per cycle
//   out as results are popped; a closing byte gives two results (its own plus the success)
// reset: parser and job queue clear and the output register empties; file length is 0, so
//   bytes are dropped until a configuration write starts a parse
module section_stream_deframer
    import ssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             file_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             kind,
    output logic [15:0]            sect_type,
    output logic [31:0]            section_length,
    output logic [7:0]             payload_byte,
    output logic                   section_end,
    output logic [1:0]             error_code,
    output logic                   last_of_run
);

    logic     job_valid;
    ssd_job_t fr_job;
    ssd_job_t bk_job;
    logic     q_empty;
    logic     q_pop;
    logic     byte_take;

    assign cfg_ready = 1'b1;
    assign byte_take = push && !full;

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_take (byte_take),
        .file_byte (file_byte),
        .job_valid (job_valid),
        .job       (fr_job)
    );

    ssd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (fr_job),
        .full   (full),
        .rd_en  (q_pop),
        .rd_job (bk_job),
        .empty  (q_empty)
    );

    ssd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_empty      (q_empty),
        .job            (bk_job),
        .job_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .sect_type      (sect_type),
        .section_length (section_length),
        .payload_byte   (payload_byte),
        .section_end    (section_end),
        .error_code     (error_code),
        .last_of_run    (last_of_run)
    );

endmodule

@@ design/ssd_front.sv @@
// ----------------------------------------------------------------------------
// ssd_front
// Byte parser: header assembly, length and cookie checks, payload counting.
// ----------------------------------------------------------------------------
module ssd_front
    import ssd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   byte_take,
    input  logic [7:0]             file_byte,
    output logic                   job_valid,
    output ssd_job_t               job
);

    logic [31:0] file_length_reg;
    logic [15:0] cookie_reg;
    logic [55:0] hdr_shift_reg, hdr_shift_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        in_payload_reg, in_payload_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [31:0] file_left_reg, file_left_next;
    logic [15:0] cur_type_reg, cur_type_next;
    logic        halted_reg, halted_next;

    logic [31:0] fl_dec;
    logic [31:0] hdr_len;
    logic [15:0] hdr_type;
    logic [15:0] hdr_cookie;
    logic        pl_end;

    assign fl_dec     = file_left_reg - 32'd1;
    assign hdr_len    = hdr_shift_reg[31:0];
    assign hdr_type   = hdr_shift_reg[47:32];
    assign hdr_cookie = {file_byte, hdr_shift_reg[55:48]};
    assign pl_end     = (payload_left_reg == 32'd1);

    always_comb
    begin
        hdr_shift_next    = hdr_shift_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        in_payload_next   = in_payload_reg;
        payload_left_next = payload_left_reg;
        file_left_next    = file_left_reg;
        cur_type_next     = cur_type_reg;
        halted_next       = halted_reg;
        job_valid         = 1'b0;
        job               = '0;
        job.op            = JOB_ERROR;

        if (byte_take && !halted_reg && (file_left_reg != 32'd0))
        begin
            file_left_next = fl_dec;
            job_valid      = 1'b1;
            if (in_payload_reg)
            begin
                payload_left_next = payload_left_reg - 32'd1;
                job.op    = JOB_PAYLOAD;
                job.stype = cur_type_reg;
                job.data  = file_byte;
                job.send  = pl_end;
                if (pl_end)
                begin
                    in_payload_next = 1'b0;
                    if (fl_dec == 32'd0)
                    begin
                        job.finish  = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
            else if ((hdr_cnt_reg == 3'd0) && (file_left_reg < 32'(HEADER_BYTES)))
            begin
                job.op      = JOB_ERROR;
                job.err     = ERR_TRAILING;
                halted_next = 1'b1;
            end
            else if (hdr_cnt_reg != 3'(HEADER_BYTES - 1))
            begin
                job_valid = 1'b0;
                hdr_shift_next[hdr_cnt_reg*8 +: 8] = file_byte;
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
            end
            else
            begin
                // eighth header byte: check and dispatch
                hdr_shift_next = '0;
                hdr_cnt_next   = 3'd0;
                if (hdr_len > fl_dec)
                begin
                    job.op      = JOB_ERROR;
                    job.err     = ERR_TRUNCATED;
                    halted_next = 1'b1;
                end
                else if (hdr_cookie != cookie_reg)
                begin
                    job.op      = JOB_ERROR;
                    job.err     = ERR_COOKIE;
                    halted_next = 1'b1;
                end
                else
                begin
                    cur_type_next = hdr_type;
                    job.op    = JOB_HEADER;
                    job.stype = hdr_type;
                    job.slen  = hdr_len;
                    if (hdr_len != 32'd0)
                    begin
                        in_payload_next   = 1'b1;
                        payload_left_next = hdr_len;
                    end
                    else if (fl_dec == 32'd0)
                    begin
                        job.finish  = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg  <= '0;
            cookie_reg       <= '0;
            hdr_shift_reg    <= '0;
            hdr_cnt_reg      <= '0;
            in_payload_reg   <= 1'b0;
            payload_left_reg <= '0;
            file_left_reg    <= '0;
            cur_type_reg     <= '0;
            halted_reg       <= 1'b0;
        end
        else if (cfg_we && ((cfg_index == REG_FILE_LENGTH) ||
                            (cfg_index == REG_EXPECTED_COOKIE)))
        begin
            // a write to either configuration register restarts the parse
            hdr_shift_reg    <= '0;
            hdr_cnt_reg      <= '0;
            in_payload_reg   <= 1'b0;
            payload_left_reg <= '0;
            cur_type_reg     <= '0;
            halted_reg       <= 1'b0;
            if (cfg_index == REG_FILE_LENGTH)
            begin
                file_length_reg <= cfg_data;
                file_left_reg   <= cfg_data;
            end
            else
            begin
                cookie_reg    <= cfg_data[15:0];
                file_left_reg <= file_length_reg;
            end
        end
        else
        begin
            hdr_shift_reg    <= hdr_shift_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            in_payload_reg   <= in_payload_next;
            payload_left_reg <= payload_left_next;
            file_left_reg    <= file_left_next;
            cur_type_reg     <= cur_type_next;
            halted_reg       <= halted_next;
        end
    end

`ifndef NO_ASSERTIONS
    // halted parser gives no job
    a_no_job_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !job_valid)
        else $error("job from halted parser");

    // payload bytes never outnumber the bytes left in the file
    a_payload_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (payload_left_reg <= file_left_reg))
        else $error("payload longer than file");
`endif

endmodule

@@ design/ssd_fifo.sv @@
// ----------------------------------------------------------------------------
// ssd_fifo
// Short job queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module ssd_fifo
    import ssd_pkg::*;
#(
    parameter int DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  ssd_job_t wr_job,
    output logic     full,
    input  logic     rd_en,
    output ssd_job_t rd_job,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssd_job_t             store_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_wr, do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

@@ design/ssd_back.sv @@
// ----------------------------------------------------------------------------
// ssd_back
// Result stage: expands each job into one or two results in an output register.
// ----------------------------------------------------------------------------
module ssd_back
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_empty,
    input  ssd_job_t    job,
    output logic        job_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] sect_type,
    output logic [31:0] section_length,
    output logic [7:0]  payload_byte,
    output logic        section_end,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    logic        out_valid_reg;
    logic        pend_fin_reg;
    logic [1:0]  kind_reg;
    logic [15:0] type_reg;
    logic [31:0] len_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [1:0]  err_reg;
    logic        last_reg;
    logic        can_load;

    assign can_load = !out_valid_reg || pop;
    assign job_pop  = can_load && !pend_fin_reg && !job_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_fin_reg  <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_fin_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_fin_reg  <= 1'b0;
            end
            else
            begin
                out_valid_reg <= !job_empty;
                pend_fin_reg  <= !job_empty && job.finish;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            type_reg <= '0;
            len_reg  <= '0;
            byte_reg <= '0;
            end_reg  <= 1'b0;
            err_reg  <= ERR_NONE;
            if (pend_fin_reg)
            begin
                kind_reg <= KIND_OK;
                last_reg <= 1'b1;
            end
            else
            begin
                last_reg <= !job.finish;
                case (job.op)
                    JOB_HEADER:
                    begin
                        kind_reg <= KIND_HEADER;
                        type_reg <= job.stype;
                        len_reg  <= job.slen;
                    end
                    JOB_PAYLOAD:
                    begin
                        kind_reg <= KIND_PAYLOAD;
                        type_reg <= job.stype;
                        byte_reg <= job.data;
                        end_reg  <= job.send;
                    end
                    default:
                    begin
                        kind_reg <= KIND_ERROR;
                        err_reg  <= job.err;
                    end
                endcase
            end
        end
    end

    assign empty          = !out_valid_reg;
    assign kind           = kind_reg;
    assign sect_type      = type_reg;
    assign section_length = len_reg;
    assign payload_byte   = byte_reg;
    assign section_end    = end_reg;
    assign error_code     = err_reg;
    assign last_of_run    = last_reg;

`ifndef NO_ASSERTIONS
    // a pending success always follows a shown result
    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_fin_reg |-> (out_valid_reg && !last_reg))
        else $error("pending success without open result");

    // success always closes its run
    a_ok_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_OK)) |-> last_reg)
        else $error("success result not last of run");
`endif

endmodule
